### rtl/fpa_pkg.sv
`default_nettype none

package fpa_pkg;

	localparam int FRAC_BITS   = 8;
	localparam int DATA_W      = 32;
	localparam int DIV_W       = DATA_W + FRAC_BITS;
	localparam int PIPE_N      = DIV_W;
	localparam int QUEUE_DEPTH = 2;

	typedef enum logic [3:0] {
		FN_ADD      = 4'd0,
		FN_SUB      = 4'd1,
		FN_MUL      = 4'd2,
		FN_DIV      = 4'd3,
		FN_GT       = 4'd4,
		FN_LT       = 4'd5,
		FN_GE       = 4'd6,
		FN_LE       = 4'd7,
		FN_EQ       = 4'd8,
		FN_NE       = 4'd9,
		FN_MIN      = 4'd10,
		FN_MAX      = 4'd11,
		FN_INC      = 4'd12,
		FN_DEC      = 4'd13,
		FN_FROM_INT = 4'd14,
		FN_TO_INT   = 4'd15
	} func_t;

	// classified item as held in the queue
	typedef struct packed {
		func_t              func;
		logic [DATA_W-1:0]  a;
		logic [DATA_W-1:0]  b;
		logic [DATA_W-1:0]  mag_a;
		logic [DATA_W-1:0]  mag_b;
		logic               neg;
		logic               b_zero;
		logic               is_mul;
		logic               is_div;
	} item_t;

	typedef struct packed {
		logic [DATA_W-1:0] rem;
		logic [DIV_W-1:0]  dq;
	} div_t;

	typedef struct packed {
		logic              is_mul;
		logic              is_div;
		logic              dz;
		logic              neg;
		logic              cmp;
		logic [DATA_W-1:0] res;
		logic [DATA_W-1:0] mb;
		logic [DATA_W-1:0] rem;
		logic [DIV_W-1:0]  dq;
	} stage_t;

	typedef struct packed {
		logic [DATA_W-1:0] value;
		logic              cmp;
		logic              dz;
	} result_t;

	// one restoring step: quotient bit shifts into the low end of dq
	function automatic div_t div_step(input logic [DATA_W-1:0] rem,
	                                  input logic [DIV_W-1:0]  dq,
	                                  input logic [DATA_W-1:0] mb);
		logic [DATA_W:0] t;
		logic [DATA_W:0] diff;
		logic            ge;
		div_t            r;
		t    = {rem, dq[DIV_W-1]};
		diff = t - {1'b0, mb};
		ge   = (t >= {1'b0, mb});
		r.rem = ge ? diff[DATA_W-1:0] : t[DATA_W-1:0];
		r.dq  = {dq[DIV_W-2:0], ge};
		return r;
	endfunction

endpackage

`default_nettype wire

### rtl/fixed_point_alu.sv
// Signed 32-bit fixed-point ALU with eight fraction bits (Q24.8). Items are pushed in with
// an operation code and two raw operands; each gives one result, popped in order. A new item
// is taken every cycle while the result side keeps popping. From the accepting edge to the
// result showing (empty low), an item is registered in the two-entry input queue, then
// passes 40 pipeline stages set by the divider, which resolves one quotient bit per stage
// over the 40-bit scaled dividend; the last stage loads the output register. Every operation
// runs the full pipeline so results stay in order. When pop stays low the pipeline holds and
// the input queue absorbs two more items before full rises.
`default_nettype none

module fixed_point_alu (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       push,
	output logic                            full,
	input  wire logic [3:0]                 func,
	input  wire logic signed [fpa_pkg::DATA_W-1:0] operand_a,
	input  wire logic signed [fpa_pkg::DATA_W-1:0] operand_b,
	output logic                            empty,
	input  wire logic                       pop,
	output logic signed [fpa_pkg::DATA_W-1:0] result_value,
	output logic                            compare_true,
	output logic                            div_by_zero
);
	import fpa_pkg::*;

	logic    wr_en;
	item_t   wr_item;
	logic    q_valid;
	item_t   q_item;
	logic    q_take;
	result_t res;

	fpa_front u_front (
		.push      (push),
		.full      (full),
		.func      (func),
		.operand_a (operand_a),
		.operand_b (operand_b),
		.wr_en     (wr_en),
		.wr_item   (wr_item)
	);

	fpa_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_item  (wr_item),
		.full     (full),
		.rd_en    (q_take),
		.rd_valid (q_valid),
		.rd_item  (q_item)
	);

	fpa_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (q_valid),
		.in_item  (q_item),
		.in_take  (q_take),
		.empty    (empty),
		.pop      (pop),
		.result   (res)
	);

	assign result_value = res.value;
	assign compare_true = res.cmp;
	assign div_by_zero  = res.dz;

endmodule

`default_nettype wire

### rtl/fpa_front.sv
`default_nettype none

module fpa_front (
	input  wire logic                     push,
	input  wire logic                     full,
	input  wire logic [3:0]               func,
	input  wire logic [fpa_pkg::DATA_W-1:0] operand_a,
	input  wire logic [fpa_pkg::DATA_W-1:0] operand_b,
	output logic                          wr_en,
	output fpa_pkg::item_t                wr_item
);
	import fpa_pkg::*;

	logic sa;
	logic sb;

	assign sa    = operand_a[DATA_W-1];
	assign sb    = operand_b[DATA_W-1];
	assign wr_en = push && !full;

	always_comb begin
		wr_item.func   = func_t'(func);
		wr_item.a      = operand_a;
		wr_item.b      = operand_b;
		// two's complement negate also gives the right magnitude for the most negative value
		wr_item.mag_a  = sa ? (~operand_a + 1'b1) : operand_a;
		wr_item.mag_b  = sb ? (~operand_b + 1'b1) : operand_b;
		wr_item.neg    = sa ^ sb;
		wr_item.b_zero = (operand_b == '0);
		wr_item.is_mul = (func_t'(func) == FN_MUL);
		wr_item.is_div = (func_t'(func) == FN_DIV);
	end

endmodule

`default_nettype wire

### rtl/fpa_queue.sv
`default_nettype none

module fpa_queue (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            wr_en,
	input  wire fpa_pkg::item_t  wr_item,
	output logic                 full,
	input  wire logic            rd_en,
	output logic                 rd_valid,
	output fpa_pkg::item_t       rd_item
);
	import fpa_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	item_t             mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              do_rd;

	assign full     = (count_q == CNT_W'(QUEUE_DEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_item  = mem_q[rd_ptr_q];
	assign do_rd    = rd_en && rd_valid;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({wr_en, do_rd})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

### rtl/fpa_back.sv
`default_nettype none

module fpa_back (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	input  wire fpa_pkg::item_t  in_item,
	output logic                 in_take,
	output logic                 empty,
	input  wire logic            pop,
	output fpa_pkg::result_t     result
);
	import fpa_pkg::*;

	logic [PIPE_N-1:0]            vld_q;
	stage_t                       pipe_q [PIPE_N];
	stage_t                       nxt    [PIPE_N];
	logic signed [2*DATA_W-1:0]   prod_d;
	logic signed [2*DATA_W-1:0]   prod_s1;
	result_t                      out_q;
	logic                         out_valid_q;
	result_t                      fin;
	logic [DATA_W-1:0]            quot;
	logic                         adv;
	logic                         move;
	logic                         lt;
	logic                         gt;
	logic                         eq;
	div_t                         ds0;
	div_t                         dsk [PIPE_N];

	// the whole pipe moves together; it holds only when the output slot is blocked
	assign move    = vld_q[PIPE_N-1] && (!out_valid_q || pop);
	assign adv     = !vld_q[PIPE_N-1] || move;
	assign in_take = adv;
	assign empty   = !out_valid_q;
	assign result  = out_q;

	// first stage: simple operations, the full product and the first quotient bit
	always_comb begin
		lt     = ($signed(in_item.a) < $signed(in_item.b));
		gt     = ($signed(in_item.b) < $signed(in_item.a));
		eq     = (in_item.a == in_item.b);
		prod_d = $signed(in_item.a) * $signed(in_item.b);
		ds0    = div_step('0, DIV_W'(in_item.mag_a) << FRAC_BITS, in_item.mag_b);

		nxt[0]        = '0;
		nxt[0].is_mul = in_item.is_mul;
		nxt[0].is_div = in_item.is_div;
		nxt[0].dz     = in_item.is_div && in_item.b_zero;
		nxt[0].neg    = in_item.neg;
		nxt[0].mb     = in_item.mag_b;
		nxt[0].rem    = ds0.rem;
		nxt[0].dq     = ds0.dq;
		unique case (in_item.func)
			FN_ADD:      nxt[0].res = in_item.a + in_item.b;
			FN_SUB:      nxt[0].res = in_item.a - in_item.b;
			FN_MUL:      nxt[0].res = '0;
			FN_DIV:      nxt[0].res = '0;
			FN_GT:       nxt[0].cmp = gt;
			FN_LT:       nxt[0].cmp = lt;
			FN_GE:       nxt[0].cmp = !lt;
			FN_LE:       nxt[0].cmp = !gt;
			FN_EQ:       nxt[0].cmp = eq;
			FN_NE:       nxt[0].cmp = !eq;
			FN_MIN:      nxt[0].res = lt ? in_item.a : in_item.b;
			FN_MAX:      nxt[0].res = gt ? in_item.a : in_item.b;
			FN_INC:      nxt[0].res = in_item.a + 1'b1;
			FN_DEC:      nxt[0].res = in_item.a - 1'b1;
			FN_FROM_INT: nxt[0].res = in_item.a << FRAC_BITS;
			FN_TO_INT:   nxt[0].res = DATA_W'($signed(in_item.a) >>> FRAC_BITS);
		endcase
		if (nxt[0].cmp) begin
			nxt[0].res = DATA_W'(1);
		end

		// later stages: one quotient bit each, product scaling in the second
		dsk[0] = '0;
		for (int k = 1; k < PIPE_N; k++) begin
			dsk[k]     = div_step(pipe_q[k-1].rem, pipe_q[k-1].dq, pipe_q[k-1].mb);
			nxt[k]     = pipe_q[k-1];
			nxt[k].rem = dsk[k].rem;
			nxt[k].dq  = dsk[k].dq;
			if (k == 1 && pipe_q[0].is_mul) begin
				nxt[k].res = prod_s1[FRAC_BITS +: DATA_W];
			end
		end
	end

	always_comb begin
		fin       = '0;
		quot      = pipe_q[PIPE_N-1].dq[DATA_W-1:0];
		fin.cmp   = pipe_q[PIPE_N-1].cmp;
		fin.dz    = pipe_q[PIPE_N-1].dz;
		priority if (pipe_q[PIPE_N-1].dz) begin
			fin.value = '0;
		end else if (pipe_q[PIPE_N-1].is_div) begin
			fin.value = pipe_q[PIPE_N-1].neg ? (~quot + 1'b1) : quot;
		end else begin
			fin.value = pipe_q[PIPE_N-1].res;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s1 <= prod_d;
			for (int k = 0; k < PIPE_N; k++) begin
				pipe_q[k] <= nxt[k];
			end
		end
		if (move) begin
			out_q <= fin;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv) begin
				vld_q <= {vld_q[PIPE_N-2:0], in_valid};
			end
			if (move) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

`ifndef SYNTH
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(vld_q))
		else $error("pipe valids moved while stalled");
	a_dz_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.dz |-> out_q.value == '0)
		else $error("divide by zero with nonzero result");
	a_cmp_one: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.cmp |-> (out_q.value == DATA_W'(1)) && !out_q.dz)
		else $error("comparison result inconsistent");
	a_move_fill: assert property (@(posedge clk) disable iff (!arst_n)
		move |=> out_valid_q)
		else $error("finished item lost at output");
`endif

endmodule

`default_nettype wire

### bench/tb_fixed_point_alu.sv
`default_nettype none

module tb_fixed_point_alu;

	import fpa_pkg::*;

	localparam int RANDOM_ITEMS = 400;
	localparam int HOLD_AT      = 120;
	localparam int HOLD_CYCLES  = 800;
	localparam int DRAIN_CYCLES = 60;
	localparam int LIMIT_CYCLES = 200000;

	typedef struct packed {
		logic [DATA_W-1:0] value;
		logic              cmp;
		logic              dz;
	} alu_out_t;

	typedef struct packed {
		func_t             fn;
		logic [DATA_W-1:0] a;
		logic [DATA_W-1:0] b;
		logic              typed;
		logic [DATA_W-1:0] value;
		logic              cmp;
		logic              dz;
	} vector_t;

	logic                     clk;
	logic                     arst_n;
	logic                     push;
	logic                     full;
	logic [3:0]               func;
	logic signed [DATA_W-1:0] operand_a;
	logic signed [DATA_W-1:0] operand_b;
	logic                     empty;
	logic                     pop;
	logic signed [DATA_W-1:0] result_value;
	logic                     compare_true;
	logic                     div_by_zero;

	alu_out_t pending_results [$];
	int       error_count = 0;
	int       drained     = 0;

	// rows with typed = 0 take their expectation from the predictor
	vector_t directed_vectors [0:23] = '{
		'{FN_ADD,      32'h0000_0000, 32'h0000_0000, 1'b1, 32'h0000_0000, 1'b0, 1'b0},
		'{FN_ADD,      32'h7FFF_FFFF, 32'h0000_0001, 1'b1, 32'h8000_0000, 1'b0, 1'b0},
		'{FN_SUB,      32'h8000_0000, 32'h0000_0001, 1'b1, 32'h7FFF_FFFF, 1'b0, 1'b0},
		'{FN_MUL,      32'h0000_0100, 32'h0000_0100, 1'b1, 32'h0000_0100, 1'b0, 1'b0},
		'{FN_MUL,      32'h8000_0000, 32'h8000_0000, 1'b0, 32'h0000_0000, 1'b0, 1'b0},
		'{FN_MUL,      32'hFFFF_FFFF, 32'h0000_0001, 1'b1, 32'hFFFF_FFFF, 1'b0, 1'b0},
		'{FN_DIV,      32'h0000_0100, 32'h0000_0000, 1'b1, 32'h0000_0000, 1'b0, 1'b1},
		'{FN_DIV,      32'h8000_0000, 32'hFFFF_FFFF, 1'b0, 32'h0000_0000, 1'b0, 1'b0},
		'{FN_DIV,      32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 32'h0000_0000, 1'b0, 1'b0},
		'{FN_DIV,      32'hFFFF_FF00, 32'h0000_0300, 1'b0, 32'h0000_0000, 1'b0, 1'b0},
		'{FN_GT,       32'h7FFF_FFFF, 32'h8000_0000, 1'b1, 32'h0000_0001, 1'b1, 1'b0},
		'{FN_LT,       32'h7FFF_FFFF, 32'h8000_0000, 1'b1, 32'h0000_0000, 1'b0, 1'b0},
		'{FN_GE,       32'h0000_0005, 32'h0000_0005, 1'b1, 32'h0000_0001, 1'b1, 1'b0},
		'{FN_LE,       32'h8000_0000, 32'h7FFF_FFFF, 1'b1, 32'h0000_0001, 1'b1, 1'b0},
		'{FN_EQ,       32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'h0000_0001, 1'b1, 1'b0},
		'{FN_NE,       32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000, 1'b0, 1'b0},
		'{FN_MIN,      32'h8000_0000, 32'h7FFF_FFFF, 1'b1, 32'h8000_0000, 1'b0, 1'b0},
		'{FN_MAX,      32'h0000_1234, 32'h0000_1234, 1'b1, 32'h0000_1234, 1'b0, 1'b0},
		'{FN_INC,      32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'h8000_0000, 1'b0, 1'b0},
		'{FN_DEC,      32'h8000_0000, 32'hFFFF_FFFF, 1'b1, 32'h7FFF_FFFF, 1'b0, 1'b0},
		'{FN_FROM_INT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FF00, 1'b0, 1'b0},
		'{FN_FROM_INT, 32'h0080_0000, 32'h0000_0000, 1'b0, 32'h0000_0000, 1'b0, 1'b0},
		'{FN_TO_INT,   32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 32'hFFFF_FFFF, 1'b0, 1'b0},
		'{FN_TO_INT,   32'h8000_0000, 32'hFFFF_FFFF, 1'b1, 32'hFF80_0000, 1'b0, 1'b0}
	};

	fixed_point_alu u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.func         (func),
		.operand_a    (operand_a),
		.operand_b    (operand_b),
		.empty        (empty),
		.pop          (pop),
		.result_value (result_value),
		.compare_true (compare_true),
		.div_by_zero  (div_by_zero)
	);

	function automatic alu_out_t fixed_point_result(input func_t fn, input logic [DATA_W-1:0] a,
	                                                input logic [DATA_W-1:0] b);
		logic signed [DATA_W-1:0] sa;
		logic signed [DATA_W-1:0] sb;
		logic signed [63:0]       wa;
		logic signed [63:0]       wb;
		logic signed [63:0]       wide;
		alu_out_t                 r;
		sa   = a;
		sb   = b;
		wa   = sa;
		wb   = sb;
		r    = '0;
		case (fn)
			FN_ADD:      r.value = a + b;
			FN_SUB:      r.value = a - b;
			FN_MUL: begin
				wide    = (wa * wb) >>> FRAC_BITS;
				r.value = wide[DATA_W-1:0];
			end
			FN_DIV: begin
				if (b == '0) begin
					r.dz = 1'b1;
				end else begin
					// signed divide truncates toward zero
					wide    = (wa <<< FRAC_BITS) / wb;
					r.value = wide[DATA_W-1:0];
				end
			end
			FN_GT:       r.cmp = sa > sb;
			FN_LT:       r.cmp = sa < sb;
			FN_GE:       r.cmp = sa >= sb;
			FN_LE:       r.cmp = sa <= sb;
			FN_EQ:       r.cmp = a == b;
			FN_NE:       r.cmp = a != b;
			FN_MIN:      r.value = (sa < sb) ? a : b;
			FN_MAX:      r.value = (sb < sa) ? a : b;
			FN_INC:      r.value = a + 1;
			FN_DEC:      r.value = a - 1;
			FN_FROM_INT: r.value = a << FRAC_BITS;
			default:     r.value = sa >>> FRAC_BITS;
		endcase
		if (fn inside {FN_GT, FN_LT, FN_GE, FN_LE, FN_EQ, FN_NE})
			r.value = {{(DATA_W-1){1'b0}}, r.cmp};
		return r;
	endfunction

	function automatic logic [DATA_W-1:0] pick_operand();
		logic [DATA_W-1:0] v;
		case ($urandom_range(0, 9))
			0: begin
				case ($urandom_range(0, 5))
					0:       v = 32'h8000_0000;
					1:       v = 32'h7FFF_FFFF;
					2:       v = 32'hFFFF_FFFF;
					3:       v = 32'h0000_0000;
					4:       v = 32'h0000_0001;
					default: v = 32'h8000_0001;
				endcase
			end
			1:       v = $urandom_range(0, 2047) - 1024;
			2:       v = ($urandom_range(0, 64) - 32) << FRAC_BITS;
			default: v = $urandom;
		endcase
		return v;
	endfunction

	task automatic offer_item(input func_t fn, input logic [DATA_W-1:0] a,
	                          input logic [DATA_W-1:0] b, input alu_out_t want, input bit no_gap);
		int gap;
		gap = no_gap ? 0 : $urandom_range(0, 12);
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push      <= 1'b1;
		func      <= fn;
		operand_a <= a;
		operand_b <= b;
		@(posedge clk);
		while (full !== 1'b0) @(posedge clk);
		pending_results.push_back(want);
	endtask

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#(20 * LIMIT_CYCLES);
		$display("*** FAILED ***");
		$finish;
	end

	// result side: random stalls, stall-free stretches, one long hold-off so the input backs up
	initial begin : result_drain
		int       stall;
		alu_out_t got;
		alu_out_t want;
		pop <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (drained == HOLD_AT)
				stall = HOLD_CYCLES;
			else if ((drained / 50) % 4 == 1)
				stall = 0;
			else
				stall = $urandom_range(0, 12);
			if (stall > 0) begin
				pop <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			pop <= 1'b1;
			@(posedge clk);
			while (empty !== 1'b0) @(posedge clk);
			got = '{result_value, compare_true, div_by_zero};
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result transfer, value %h cmp %b dz %b",
				         $time, got.value, got.cmp, got.dz);
				error_count++;
			end else begin
				want = pending_results.pop_front();
				if (got.value !== want.value) begin
					$display("%0t: result_value expected %h actual %h",
					         $time, want.value, got.value);
					error_count++;
				end
				if (got.cmp !== want.cmp) begin
					$display("%0t: compare_true expected %b actual %b",
					         $time, want.cmp, got.cmp);
					error_count++;
				end
				if (got.dz !== want.dz) begin
					$display("%0t: div_by_zero expected %b actual %b",
					         $time, want.dz, got.dz);
					error_count++;
				end
			end
			drained++;
		end
	end

	initial begin : stimulus
		vector_t           row;
		alu_out_t          want;
		func_t             fn;
		logic [DATA_W-1:0] a;
		logic [DATA_W-1:0] b;
		arst_n    <= 1'b0;
		push      <= 1'b0;
		func      <= FN_ADD;
		operand_a <= '0;
		operand_b <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_vectors[i]) begin
			row = directed_vectors[i];
			if (row.typed)
				want = '{row.value, row.cmp, row.dz};
			else
				want = fixed_point_result(row.fn, row.a, row.b);
			offer_item(row.fn, row.a, row.b, want, 1'b0);
		end

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			fn = func_t'($urandom_range(0, 15));
			a  = pick_operand();
			b  = pick_operand();
			if ($urandom_range(0, 7) == 0)
				b = a;
			if (fn == FN_DIV && $urandom_range(0, 5) == 0)
				b = '0;
			// every fourth stretch of items goes back to back
			offer_item(fn, a, b, fixed_point_result(fn, a, b), (n / 40) % 4 == 2);
		end
		push <= 1'b0;

		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

`default_nettype wire
